[rtl/eth_ipv4_tcp_header_parser_core_macros.svh]
// Assertion helpers for the header parser; clk and rst are the module's own ports.
`ifndef ETH_IPV4_TCP_HEADER_PARSER_CORE_MACROS_SVH
`define ETH_IPV4_TCP_HEADER_PARSER_CORE_MACROS_SVH

// Same-cycle implication, quiet during reset
`define EITP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, quiet during reset
`define EITP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/eitp_pkg.sv]
`default_nettype none

package eitp_pkg;

  // Result kinds
  localparam logic KIND_HDR = 1'b0;
  localparam logic KIND_PAY = 1'b1;

  // Frame byte offsets of the captured fields
  localparam int OFS_SRC_MAC  = 6;
  localparam int OFS_ETYPE_HI = 12;
  localparam int OFS_ETYPE_LO = 13;
  localparam int ETH_HDR_LEN  = 14;
  localparam int OFS_TOTAL_HI = 16;
  localparam int OFS_TOTAL_LO = 17;
  localparam int OFS_PROTO    = 23;
  localparam int OFS_SRC_IP   = 26;
  localparam int OFS_DST_IP   = 30;
  localparam int OFS_IP_END   = 34;

  // Offsets relative to the start of the TCP header
  localparam int REL_PORTS_END = 4;
  localparam int REL_DOFF      = 12;

  localparam logic [15:0] ETYPE_IPV4    = 16'h0800;
  localparam logic [7:0]  PROTO_TCP     = 8'h06;
  localparam logic [3:0]  MIN_HDR_WORDS = 4'd5;
  localparam logic [7:0]  DOT_CHAR      = 8'h2E;

  typedef struct packed {
    logic        kind;
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] payload_length;
    logic [7:0]  payload_char;
    logic        last;
  } res_t;

  // Printable, tab, LF and CR pass; anything else shows as a dot
  function automatic logic [7:0] show_char(input logic [7:0] b);
    logic keep;
    keep = (b >= 8'h20 && b <= 8'h7E) || b == 8'h09 || b == 8'h0A || b == 8'h0D;
    return keep ? b : DOT_CHAR;
  endfunction

endpackage

`default_nettype wire

[rtl/eth_ipv4_tcp_header_parser_core.sv]
// Ethernet / IPv4 / TCP header parser.
// Input channel (in_valid/in_ready): one frame byte per item, frame_end on
// the last byte of each frame. Output channel (out_valid/out_ready): one
// header summary (kind 0) when the last TCP header byte arrives, then one
// payload character (kind 1) per payload byte, with last on the final result
// of the frame. Non-IPv4, non-TCP, short or malformed frames give no result.
// Results are registered in the output register, or in the skid register.
// Throughput: one byte per cycle while in_ready is high; each byte needs only
// offset compares and a field capture, between parser state and output register.
// Stall: the output register is backed by a one-item skid register, so a byte
// is still taken in the cycle the receiver first stalls; in_ready drops only
// while the skid register holds an item, and rises once the receiver drains.
// Reset: synchronous, active high; clears the byte offset, the parse phase
// and both output slots. The first byte after reset is offset zero.
// OFFSET_BITS sizes the saturating byte-offset counter.
`default_nettype none

module eth_ipv4_tcp_header_parser_core #(
  parameter int OFFSET_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  frame_byte,
  input  wire logic        frame_end,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             kind,
  output logic [47:0]      dst_mac,
  output logic [47:0]      src_mac,
  output logic [31:0]      src_addr,
  output logic [31:0]      dst_addr,
  output logic [15:0]      src_port,
  output logic [15:0]      dst_port,
  output logic [15:0]      payload_length,
  output logic [7:0]       payload_char,
  output logic             last
);

  `include "eth_ipv4_tcp_header_parser_core_macros.svh"

  logic           take;
  logic           res_valid;
  eitp_pkg::res_t res;

  logic           skid_valid;
  eitp_pkg::res_t out_res;
  eitp_pkg::res_t skid_res;
  logic           pop;
  logic           push;

  assign in_ready = !skid_valid;
  assign take     = in_valid && in_ready;
  assign pop      = out_valid && out_ready;
  assign push     = take && res_valid;

  eitp_parser #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .frame_byte (frame_byte),
    .frame_end  (frame_end),
    .res_valid  (res_valid),
    .res        (res)
  );

  // Output register with skid slot
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop && skid_valid) begin
      out_res    <= skid_res;
      skid_valid <= 1'b0;
    end else if (pop || !out_valid) begin
      out_valid <= push;
      if (push) begin
        out_res <= res;
      end
    end else if (push) begin
      skid_res   <= res;
      skid_valid <= 1'b1;
    end
  end

  assign kind           = out_res.kind;
  assign dst_mac        = out_res.dst_mac;
  assign src_mac        = out_res.src_mac;
  assign src_addr       = out_res.src_addr;
  assign dst_addr       = out_res.dst_addr;
  assign src_port       = out_res.src_port;
  assign dst_port       = out_res.dst_port;
  assign payload_length = out_res.payload_length;
  assign payload_char   = out_res.payload_char;
  assign last           = out_res.last;

  // Skid slot is only filled behind a held output item
  `EITP_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid, "skid item without output item")
  // A result arriving while the output stalls lands in the skid slot
  `EITP_ASSERT_NEXT(a_stall_to_skid, push && out_valid && !out_ready, skid_valid, "stalled result lost")
  // Header summary not marked last must announce a payload
  `EITP_ASSERT_NOW(a_hdr_last, push && res.kind == eitp_pkg::KIND_HDR && !frame_end, res.last == (res.payload_length == 16'd0), "header last flag inconsistent")

endmodule

`default_nettype wire

[rtl/eitp_parser.sv]
`default_nettype none

module eitp_parser #(
  parameter int OFFSET_BITS = 16
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            take,
  input  wire logic [7:0]      frame_byte,
  input  wire logic            frame_end,
  output logic                 res_valid,
  output eitp_pkg::res_t       res
);

  typedef enum logic [1:0] {
    PH_HDR  = 2'd0,
    PH_PAY  = 2'd1,
    PH_DROP = 2'd2
  } phase_t;

  typedef logic [OFFSET_BITS-1:0] ofs_t;

  ofs_t        byte_offset, byte_offset_next;
  phase_t      parse_phase, parse_phase_next;
  logic [47:0] dst_mac_reg, dst_mac_reg_next;
  logic [47:0] src_mac_reg, src_mac_reg_next;
  logic [7:0]  ethertype_hi, ethertype_hi_next;
  logic [5:0]  ip_hdr_bytes, ip_hdr_bytes_next;
  logic [15:0] ip_total_bytes, ip_total_bytes_next;
  logic [31:0] src_addr_reg, src_addr_reg_next;
  logic [31:0] dst_addr_reg, dst_addr_reg_next;
  logic [31:0] ports_reg, ports_reg_next;
  logic [5:0]  tcp_hdr_bytes, tcp_hdr_bytes_next;
  logic [15:0] payload_left, payload_left_next;

  ofs_t        o;
  ofs_t        hdr_end;
  ofs_t        rel;
  logic [6:0]  hl;
  logic [15:0] pl;
  logic [15:0] left_dec;

  assign o        = byte_offset;
  assign hdr_end  = ofs_t'(eitp_pkg::ETH_HDR_LEN) + ofs_t'(ip_hdr_bytes);
  assign rel      = o - hdr_end;
  assign hl       = {1'b0, ip_hdr_bytes} + {1'b0, tcp_hdr_bytes};
  assign pl       = (ip_total_bytes > 16'(hl)) ? ip_total_bytes - 16'(hl) : 16'd0;
  assign left_dec = payload_left - 16'd1;

  // Field capture, drop decisions and result build for one item
  always_comb begin
    byte_offset_next    = byte_offset;
    parse_phase_next    = parse_phase;
    dst_mac_reg_next    = dst_mac_reg;
    src_mac_reg_next    = src_mac_reg;
    ethertype_hi_next   = ethertype_hi;
    ip_hdr_bytes_next   = ip_hdr_bytes;
    ip_total_bytes_next = ip_total_bytes;
    src_addr_reg_next   = src_addr_reg;
    dst_addr_reg_next   = dst_addr_reg;
    ports_reg_next      = ports_reg;
    tcp_hdr_bytes_next  = tcp_hdr_bytes;
    payload_left_next   = payload_left;
    res_valid           = 1'b0;
    res                 = '0;

    case (parse_phase)
      PH_HDR: begin
        if (o < ofs_t'(eitp_pkg::OFS_SRC_MAC)) begin
          dst_mac_reg_next = {dst_mac_reg[39:0], frame_byte};
        end else if (o < ofs_t'(eitp_pkg::OFS_ETYPE_HI)) begin
          src_mac_reg_next = {src_mac_reg[39:0], frame_byte};
        end else if (o == ofs_t'(eitp_pkg::OFS_ETYPE_HI)) begin
          ethertype_hi_next = frame_byte;
        end else if (o == ofs_t'(eitp_pkg::OFS_ETYPE_LO)) begin
          if ({ethertype_hi, frame_byte} != eitp_pkg::ETYPE_IPV4) begin
            parse_phase_next = PH_DROP;
          end
        end else if (o == ofs_t'(eitp_pkg::ETH_HDR_LEN)) begin
          ip_hdr_bytes_next = {frame_byte[3:0], 2'b00};
          if (frame_byte[3:0] < eitp_pkg::MIN_HDR_WORDS) begin
            parse_phase_next = PH_DROP;
          end
        end else if (o == ofs_t'(eitp_pkg::OFS_TOTAL_HI) ||
                     o == ofs_t'(eitp_pkg::OFS_TOTAL_LO)) begin
          ip_total_bytes_next = {ip_total_bytes[7:0], frame_byte};
        end else if (o == ofs_t'(eitp_pkg::OFS_PROTO)) begin
          if (frame_byte != eitp_pkg::PROTO_TCP) begin
            parse_phase_next = PH_DROP;
          end
        end else if (o >= ofs_t'(eitp_pkg::OFS_SRC_IP) &&
                     o <  ofs_t'(eitp_pkg::OFS_DST_IP)) begin
          src_addr_reg_next = {src_addr_reg[23:0], frame_byte};
        end else if (o >= ofs_t'(eitp_pkg::OFS_DST_IP) &&
                     o <  ofs_t'(eitp_pkg::OFS_IP_END)) begin
          dst_addr_reg_next = {dst_addr_reg[23:0], frame_byte};
        end else if (o >= hdr_end) begin
          if (rel < ofs_t'(eitp_pkg::REL_PORTS_END)) begin
            ports_reg_next = {ports_reg[23:0], frame_byte};
          end else if (rel == ofs_t'(eitp_pkg::REL_DOFF)) begin
            tcp_hdr_bytes_next = {frame_byte[7:4], 2'b00};
            if (frame_byte[7:4] < eitp_pkg::MIN_HDR_WORDS) begin
              parse_phase_next = PH_DROP;
            end
          end else if (rel > ofs_t'(eitp_pkg::REL_DOFF) &&
                       rel == ofs_t'(tcp_hdr_bytes) - ofs_t'(1)) begin
            // Last TCP header byte: header summary
            payload_left_next  = pl;
            res_valid          = 1'b1;
            res.kind           = eitp_pkg::KIND_HDR;
            res.dst_mac        = dst_mac_reg;
            res.src_mac        = src_mac_reg;
            res.src_addr       = src_addr_reg;
            res.dst_addr       = dst_addr_reg;
            res.src_port       = ports_reg[31:16];
            res.dst_port       = ports_reg[15:0];
            res.payload_length = pl;
            res.last           = frame_end || (pl == 16'd0);
            parse_phase_next   = (pl == 16'd0) ? PH_DROP : PH_PAY;
          end
        end
      end
      PH_PAY: begin
        payload_left_next = left_dec;
        res_valid         = 1'b1;
        res.kind          = eitp_pkg::KIND_PAY;
        res.payload_char  = eitp_pkg::show_char(frame_byte);
        res.last          = frame_end || (left_dec == 16'd0);
        if (left_dec == 16'd0) begin
          parse_phase_next = PH_DROP;
        end
      end
      default: begin
        // discard until frame end
      end
    endcase

    // Offset: restart on frame end (back to the header phase), otherwise count up and saturate
    if (frame_end) begin
      byte_offset_next = '0;
      parse_phase_next = PH_HDR;
    end else if (byte_offset != '1) begin
      byte_offset_next = byte_offset + ofs_t'(1);
    end
  end

  // Parser state; captures need no reset, every field is rewritten before use
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset <= '0;
      parse_phase <= PH_HDR;
    end else if (take) begin
      byte_offset <= byte_offset_next;
      parse_phase <= parse_phase_next;
    end
    if (take) begin
      dst_mac_reg    <= dst_mac_reg_next;
      src_mac_reg    <= src_mac_reg_next;
      ethertype_hi   <= ethertype_hi_next;
      ip_hdr_bytes   <= ip_hdr_bytes_next;
      ip_total_bytes <= ip_total_bytes_next;
      src_addr_reg   <= src_addr_reg_next;
      dst_addr_reg   <= dst_addr_reg_next;
      ports_reg      <= ports_reg_next;
      tcp_hdr_bytes  <= tcp_hdr_bytes_next;
      payload_left   <= payload_left_next;
    end
  end

endmodule

`default_nettype wire
